[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define BFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define BFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/bfr_pkg.sv]
// ----------------------------------------------------------------------------
// bfr_pkg
// Types and constants for the byte FIFO with replay: beat structs, operation
// codes, ring-adder operations and default sizes.
// ----------------------------------------------------------------------------
package bfr_pkg;

  // Default sizes
  localparam int DEPTH_DEF = 4096;
  localparam int BPI_DEF   = 8;

  // Width of the count fields in a result beat
  localparam int OUT_CNT_W = 13;

  // Operation codes
  localparam logic [2:0] K_WRITE     = 3'd0;
  localparam logic [2:0] K_WRITE_CLR = 3'd1;
  localparam logic [2:0] K_SLIDE     = 3'd2;
  localparam logic [2:0] K_READ      = 3'd3;
  localparam logic [2:0] K_READ_LOOP = 3'd4;
  localparam logic [2:0] K_PEEK      = 3'd5;
  localparam logic [2:0] K_TOSS      = 3'd6;
  localparam logic [2:0] K_CLEAR     = 3'd7;

  // Ring adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Input beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] payload;
    logic [3:0]  byte_count;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [63:0]          read_bytes;
    logic [OUT_CNT_W-1:0] return_value;
    logic [OUT_CNT_W-1:0] bytes_in_use;
    logic [OUT_CNT_W-1:0] free_space;
  } out_item_t;

endpackage

[rtl/core/byte_fifo_with_replay_unit.sv]
// ----------------------------------------------------------------------------
// byte_fifo_with_replay_unit
// Byte FIFO over a ring of DEPTH bytes with write, write-or-clear, slide
// write, read, looped replay read, peek, toss and clear.
//
//   channel | direction | handshake              | beat
//   in      | input     | in_valid_i / in_stall_o   | bfr_pkg::in_item_t
//   out     | output    | out_valid_o / out_stall_i | bfr_pkg::out_item_t
//   cfg     | input     | cfg_we_i                  | cfg_wdata_i, replay count
//
// Write-or-clear, slide write and looped read can add a second pass. The store
// moves one byte per cycle; the result beat loads in the same cycle as the input
// frees.
// Reset clears pointers and counts; the byte store needs no clearing pass.
// A stalled result beat does not block intake; the next one waits in FIN.
// ----------------------------------------------------------------------------
module byte_fifo_with_replay_unit #(
  parameter int DEPTH          = bfr_pkg::DEPTH_DEF,
  parameter int BYTES_PER_ITEM = bfr_pkg::BPI_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bfr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfr_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] alu_a;
  logic [CNT_W-1:0] alu_b;
  bfr_pkg::alu_op_e alu_op;
  logic [IDX_W-1:0] alu_res;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  // Sequencer
  bfr_ctrl #(
    .DEPTH          (DEPTH),
    .BYTES_PER_ITEM (BYTES_PER_ITEM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .alu_a_o     (alu_a),
    .alu_b_o     (alu_b),
    .alu_op_o    (alu_op),
    .alu_res_i   (alu_res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // Shared ring adder
  bfr_ring_alu #(
    .DEPTH (DEPTH)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  // Byte store
  bfr_byte_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[rtl/core/bfr_byte_ram.sv]
// ----------------------------------------------------------------------------
// bfr_byte_ram
// Byte store of the ring: one write port and one read port, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bfr_byte_ram #(
  parameter int DEPTH = bfr_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] store_q [DEPTH];
  logic [7:0] rdata_q;

  // Write one byte, read one byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    rdata_q <= store_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bfr_ring_alu.sv]
// ----------------------------------------------------------------------------
// bfr_ring_alu
// Shared ring-address adder: adds or subtracts a count to or from a ring
// position and wraps the result into 0 .. DEPTH-1 with one correction.
// ----------------------------------------------------------------------------
module bfr_ring_alu #(
  parameter int DEPTH = bfr_pkg::DEPTH_DEF
) (
  input  logic [$clog2(DEPTH+1)-1:0] a_i,
  input  logic [$clog2(DEPTH+1)-1:0] b_i,
  input  bfr_pkg::alu_op_e           op_i,
  output logic [$clog2(DEPTH)-1:0]   res_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0] DEPTH_X = (CNT_W + 1)'(DEPTH);

  logic [CNT_W:0] sum;
  logic [CNT_W:0] diff;
  logic [CNT_W:0] wrapped;

  // Add or subtract, then fold back into the ring
  always_comb begin
    sum  = {1'b0, a_i} + {1'b0, b_i};
    diff = {1'b0, a_i} - {1'b0, b_i};
    unique case (op_i)
      bfr_pkg::ALU_ADD: wrapped = (sum >= DEPTH_X) ? sum - DEPTH_X : sum;
      bfr_pkg::ALU_SUB: wrapped = diff[CNT_W] ? diff + DEPTH_X : diff;
      default:          wrapped = sum;
    endcase
  end

  assign res_o = wrapped[IDX_W-1:0];

endmodule

[rtl/core/bfr_ctrl.sv]
// ----------------------------------------------------------------------------
// bfr_ctrl
// Sequencer of the byte FIFO: holds ring pointers and counts, walks one byte
// per cycle through the byte store and drives the shared ring adder.
// ----------------------------------------------------------------------------
module bfr_ctrl #(
  parameter int DEPTH          = bfr_pkg::DEPTH_DEF,
  parameter int BYTES_PER_ITEM = bfr_pkg::BPI_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bfr_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bfr_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [15:0]                cfg_wdata_i,
  output logic [$clog2(DEPTH+1)-1:0] alu_a_o,
  output logic [$clog2(DEPTH+1)-1:0] alu_b_o,
  output bfr_pkg::alu_op_e           alu_op_o,
  input  logic [$clog2(DEPTH)-1:0]   alu_res_i,
  output logic                       ram_we_o,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr_o,
  output logic [7:0]                 ram_wdata_o,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr_o,
  input  logic [7:0]                 ram_rdata_i
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCW   = bfr_pkg::OUT_CNT_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [3:0]       BPI_C   = 4'(BYTES_PER_ITEM);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WCHK   = 4'd1;
  localparam logic [3:0] S_WADDR  = 4'd2;
  localparam logic [3:0] S_WBYTE  = 4'd3;
  localparam logic [3:0] S_TAKE   = 4'd4;
  localparam logic [3:0] S_RBYTE  = 4'd5;
  localparam logic [3:0] S_LOOP   = 4'd6;
  localparam logic [3:0] S_REWIND = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  // Control state
  logic [3:0]        state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  unread_q, unread_d;
  logic [CNT_W-1:0]  replay_q, replay_d;
  logic signed [15:0] loop_q, loop_d;
  logic              retry_q, retry_d;
  logic              rv_q, rv_d;

  // Working registers
  logic [2:0]         kind_q, kind_d;
  logic [63:0]        data_q, data_d;
  logic [3:0]         n_q, n_d;
  logic [IDX_W-1:0]   ptr_q, ptr_d;
  logic [3:0]         i_q, i_d;
  logic [3:0]         k_q, k_d;
  logic [CNT_W-1:0]   ret_q, ret_d;
  logic [63:0]        rdata_q, rdata_d;
  logic [2:0]         rpos_q, rpos_d;
  bfr_pkg::out_item_t out_item_q, out_item_d;

  logic [CNT_W-1:0]   n_ext;
  logic               wr_fin;
  logic [CNT_W-1:0]   wr_ret;
  logic               tk_fin;
  logic [3:0]         tk_k;
  logic [IDX_W-1:0]   tk_ptr;
  logic [CNT_W-1:0]   tk_unread;
  logic [3:0]         k_calc;
  logic signed [15:0] loop_next;
  logic               is_read_kind;

  assign n_ext        = CNT_W'(n_q);
  assign is_read_kind = (kind_q == bfr_pkg::K_READ) || (kind_q == bfr_pkg::K_READ_LOOP) ||
                        (kind_q == bfr_pkg::K_PEEK);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    out_valid_d = out_valid_q;
    rd_idx_d   = rd_idx_q;
    unread_d   = unread_q;
    replay_d   = replay_q;
    loop_d     = loop_q;
    retry_d    = retry_q;
    rv_d       = rv_q;
    kind_d     = kind_q;
    data_d     = data_q;
    n_d        = n_q;
    ptr_d      = ptr_q;
    i_d        = i_q;
    k_d        = k_q;
    ret_d      = ret_q;
    rdata_d    = rdata_q;
    rpos_d     = rpos_q;
    out_item_d = out_item_q;

    alu_a_o     = CNT_W'(ptr_q);
    alu_b_o     = CNT_W'(1);
    alu_op_o    = bfr_pkg::ALU_ADD;
    ram_we_o    = 1'b0;
    ram_waddr_o = ptr_q;
    ram_wdata_o = data_q[{i_q[2:0], 3'b000} +: 8];
    ram_raddr_o = ptr_q;

    wr_fin    = 1'b0;
    wr_ret    = '0;
    tk_fin    = 1'b0;
    tk_k      = '0;
    tk_ptr    = rd_idx_q;
    tk_unread = unread_q;
    k_calc    = (unread_q >= n_ext) ? n_q : unread_q[3:0];
    loop_next = (loop_q > 16'sd0) ? loop_q - 16'sd1 : loop_q;

    // Drop the result beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_item_i.kind;
          data_d  = in_item_i.payload;
          n_d     = (in_item_i.byte_count > BPI_C) ? BPI_C : in_item_i.byte_count;
          retry_d = 1'b0;
          rdata_d = '0;
          ret_d   = '0;
          rv_d    = 1'b0;
          unique case (in_item_i.kind)
            bfr_pkg::K_WRITE, bfr_pkg::K_WRITE_CLR, bfr_pkg::K_SLIDE: begin
              state_d = S_WCHK;
            end
            bfr_pkg::K_CLEAR: begin
              unread_d = '0;
              replay_d = '0;
              rd_idx_d = '0;
              state_d  = S_FIN;
            end
            default: begin
              state_d = S_TAKE;
            end
          endcase
        end
      end

      // Compact the replay window if needed, then check for room
      S_WCHK: begin
        if (n_q == 4'd0) begin
          wr_fin = 1'b1;
          wr_ret = unread_q;
        end else begin
          if ((DEPTH_C - replay_q) < n_ext) begin
            replay_d = unread_q;
          end
          if ((DEPTH_C - unread_q) < n_ext) begin
            wr_fin = 1'b1;
            wr_ret = '0;
          end else begin
            state_d = S_WADDR;
          end
        end
      end

      // Locate the write point behind the unread bytes
      S_WADDR: begin
        alu_a_o = CNT_W'(rd_idx_q);
        alu_b_o = unread_q;
        ptr_d   = alu_res_i;
        i_d     = '0;
        state_d = S_WBYTE;
      end

      // Write one byte per cycle
      S_WBYTE: begin
        ram_we_o = 1'b1;
        ptr_d    = alu_res_i;
        i_d      = i_q + 4'd1;
        if (i_q == (n_q - 4'd1)) begin
          unread_d = unread_q + n_ext;
          replay_d = replay_q + n_ext;
          wr_fin   = 1'b1;
          wr_ret   = unread_q + n_ext;
        end
      end

      // Size the read and start at the read point
      S_TAKE: begin
        if (unread_q == '0) begin
          tk_fin = 1'b1;
        end else begin
          rdata_d = '0;
          k_d     = k_calc;
          ptr_d   = rd_idx_q;
          i_d     = '0;
          if (k_calc == 4'd0) begin
            tk_fin = 1'b1;
          end else begin
            state_d = S_RBYTE;
          end
        end
      end

      // Issue one read per cycle, pack each byte in the cycle after its read
      S_RBYTE: begin
        rv_d = 1'b0;
        if (rv_q) begin
          rdata_d[{rpos_q, 3'b000} +: 8] = ram_rdata_i;
        end
        if (i_q != k_q) begin
          rv_d   = 1'b1;
          rpos_d = i_q[2:0];
          ptr_d  = alu_res_i;
          i_d    = i_q + 4'd1;
        end else if (!rv_q) begin
          tk_fin = 1'b1;
          tk_k   = k_q;
          tk_ptr = ptr_q;
        end
      end

      // Count down a replay pass
      S_LOOP: begin
        loop_d = loop_next;
        if (loop_next != 16'sd0) begin
          retry_d = 1'b1;
          state_d = S_REWIND;
        end else begin
          ret_d   = '0;
          state_d = S_FIN;
        end
      end

      // Move the read point back to the replay base
      S_REWIND: begin
        alu_a_o  = CNT_W'(rd_idx_q);
        alu_b_o  = replay_q - unread_q;
        alu_op_o = bfr_pkg::ALU_SUB;
        rd_idx_d = alu_res_i;
        unread_d = replay_q;
        state_d  = S_TAKE;
      end

      // Hand over the result beat when the output register is free
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_item_d.read_bytes   = is_read_kind ? rdata_q : '0;
          out_item_d.return_value = OCW'(ret_q);
          out_item_d.bytes_in_use = OCW'(unread_q);
          out_item_d.free_space   = OCW'(DEPTH_C - unread_q);
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Close a write attempt: retry after clear or toss, or finish
    if (wr_fin) begin
      if ((wr_ret == '0) && !retry_q && (kind_q == bfr_pkg::K_WRITE_CLR)) begin
        unread_d = '0;
        replay_d = '0;
        rd_idx_d = '0;
        retry_d  = 1'b1;
        state_d  = S_WCHK;
      end else if ((wr_ret == '0) && !retry_q && (kind_q == bfr_pkg::K_SLIDE)) begin
        retry_d = 1'b1;
        state_d = S_TAKE;
      end else begin
        ret_d   = wr_ret;
        state_d = S_FIN;
      end
    end

    // Close a read pass: advance the read point unless peeking
    if (tk_fin) begin
      tk_unread = unread_q - CNT_W'(tk_k);
      if (kind_q != bfr_pkg::K_PEEK) begin
        unread_d = tk_unread;
        rd_idx_d = tk_ptr;
      end
      unique case (kind_q)
        bfr_pkg::K_SLIDE: begin
          state_d = S_WCHK;
        end
        bfr_pkg::K_TOSS: begin
          ret_d   = tk_unread;
          state_d = S_FIN;
        end
        bfr_pkg::K_READ_LOOP: begin
          if ((tk_k == 4'd0) && !retry_q) begin
            state_d = S_LOOP;
          end else begin
            ret_d   = CNT_W'(tk_k);
            state_d = S_FIN;
          end
        end
        default: begin
          ret_d   = CNT_W'(tk_k);
          state_d = S_FIN;
        end
      endcase
    end

    // Load the replay count
    if (cfg_we_i) begin
      loop_d = $signed(cfg_wdata_i);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rd_idx_q    <= '0;
      unread_q    <= '0;
      replay_q    <= '0;
      loop_q      <= '0;
      retry_q     <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rd_idx_q    <= rd_idx_d;
      unread_q    <= unread_d;
      replay_q    <= replay_d;
      loop_q      <= loop_d;
      retry_q     <= retry_d;
      rv_q        <= rv_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    data_q     <= data_d;
    n_q        <= n_d;
    ptr_q      <= ptr_d;
    i_q        <= i_d;
    k_q        <= k_d;
    ret_q      <= ret_d;
    rdata_q    <= rdata_d;
    rpos_q     <= rpos_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/core/bfr_checker.sv]
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks for the byte FIFO with replay, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfr_checker #(
  parameter int DEPTH = bfr_pkg::DEPTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bfr_pkg::out_item_t out_item_o
);

  localparam int OCW = bfr_pkg::OUT_CNT_W;
  localparam logic [OCW-1:0] DEPTH_O = OCW'(DEPTH);

  logic           in_take;
  logic           out_held;
  logic [OCW-1:0] space_sum;
  logic           pad_ok;

  // Handshake and result terms
  assign in_take   = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign space_sum = out_item_o.bytes_in_use + out_item_o.free_space;
  assign pad_ok    = (out_item_o.return_value >= 13'd8) ||
                     ((out_item_o.read_bytes >> {out_item_o.return_value, 3'b000}) == 64'd0);

  // A stalled result beat stays
  `BFR_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_o, "stalled result dropped")

  // One beat at a time: stall right after an accept
  `BFR_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_take |=> in_stall_o, "input taken twice")

  // Bytes in use and free space add up to the ring size
  `BFR_ASSERT(a_space_sum, clk_i, rst_ni, out_valid_o |-> space_sum == DEPTH_O, "space mismatch")

  // No data bytes beyond the count moved
  `BFR_ASSERT(a_read_pad, clk_i, rst_ni, out_valid_o |-> pad_ok, "read bytes past count not zero")

  // No result beat once reset has been seen at an edge
  `BFR_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result beat during reset")

endmodule

bind byte_fifo_with_replay_unit bfr_checker #(.DEPTH(DEPTH)) u_bfr_checker (.*);
